### sv/dfs_topological_order_top_macros.svh
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef DFS_TOPOLOGICAL_ORDER_TOP_MACROS_SVH
`define DFS_TOPOLOGICAL_ORDER_TOP_MACROS_SVH

`define DFS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define DFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/dfs_pkg.sv
`default_nettype none
package dfs_pkg;

	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_MAX_EDGES    = 64;

	localparam int          CFG_W       = 5;
	localparam logic [4:0]  VCOUNT_RST  = 5'd16;

	localparam logic        CMD_ADD = 1'b0;
	localparam logic        CMD_RUN = 1'b1;

	localparam logic [1:0]  KIND_DISC = 2'd0;
	localparam logic [1:0]  KIND_TOPO = 2'd1;
	localparam logic [1:0]  KIND_ACK  = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [3:0] edge_source;
		logic [3:0] edge_target;
	} dfs_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] vertex;
		logic       edge_dropped;
		logic       last;
	} dfs_result_t;

endpackage
`default_nettype wire

### sv/dfs_topological_order_top.sv
// Add edge: accepted every cycle with busy low; the acknowledge is on result in the cycle
// after the request. Run: busy until the search and the topological output are done; each edge
// takes an S_TOP step, which issues the edge memory read, and an S_EDGE step that uses it;
// a new request is taken in any cycle with busy low.
// Results are single-cycle strobes and cannot be stalled: discovery order, then topological
// order one per cycle. Reset empties edge count and heads, clears colors, vertex_count = 16.
`default_nettype none
`include "dfs_topological_order_top_macros.svh"
module dfs_topological_order_top #(
	parameter int MAX_VERTICES = dfs_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = dfs_pkg::DEF_MAX_EDGES
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire dfs_pkg::dfs_req_t         req,
	input  wire logic                      cfg_we,
	input  wire logic [dfs_pkg::CFG_W-1:0] cfg_wdata,
	output logic                           result_valid,
	output dfs_pkg::dfs_result_t           result
);
	import dfs_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int LW = EW + 1;
	localparam logic [LW-1:0] NIL = LW'(MAX_EDGES);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ROOT = 5'b00010,
		S_TOP  = 5'b00100,
		S_EDGE = 5'b01000,
		S_TOPO = 5'b10000
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0]        vcount_q;
	logic [LW-1:0]           edges_used_q;
	logic [LW-1:0]           head_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] visited_q;
	logic [NW-1:0]           sp_q;
	logic [NW-1:0]           root_q;
	logic [NW-1:0]           fc_q;
	logic                    res_valid_q;
	dfs_result_t             result_q;

	logic [VW-1:0] stk_v_q [MAX_VERTICES];
	logic [LW-1:0] stk_c_q [MAX_VERTICES];
	logic [VW-1:0] fin_q   [MAX_VERTICES];

	logic [3+LW:0] edge_mem [MAX_EDGES];
	logic [3:0]    rd_tgt_q;
	logic [LW-1:0] rd_next_q;

	logic [NW-1:0] n_eff;
	logic          accept;
	logic          add_ok;
	logic          root_in;
	logic [VW-1:0] root_idx;
	logic [VW-1:0] src_idx;
	logic [VW-1:0] t_idx;
	logic [NW-1:0] sp_m1;
	logic [VW-1:0] top_idx;
	logic [VW-1:0] sp_idx;
	logic [VW-1:0] fc_idx;
	logic [NW-1:0] fc_m1;
	logic [VW-1:0] top_v;
	logic [LW-1:0] top_c;
	logic          t_ok;
	logic [VW-1:0] head_raddr;
	logic [LW-1:0] head_rd;
	logic          mem_we;
	logic          mem_re;

	always_comb begin
		n_eff    = (32'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);
		accept   = start && (state_q == S_IDLE);
		src_idx  = VW'(req.edge_source);
		add_ok   = (edges_used_q != NIL) && (32'(req.edge_source) < 32'(n_eff))
			&& (32'(req.edge_target) < 32'(n_eff));
		root_in  = root_q < n_eff;
		root_idx = root_q[VW-1:0];
		sp_m1    = sp_q - NW'(1);
		top_idx  = sp_m1[VW-1:0];
		sp_idx   = sp_q[VW-1:0];
		fc_idx   = fc_q[VW-1:0];
		fc_m1    = fc_q - NW'(1);
		top_v    = stk_v_q[top_idx];
		top_c    = stk_c_q[top_idx];
		t_idx    = VW'(rd_tgt_q);
		t_ok     = (32'(rd_tgt_q) < 32'(n_eff)) && !visited_q[t_idx]
			&& (32'(sp_q) < MAX_VERTICES);
		case (state_q)
			S_ROOT:  head_raddr = root_idx;
			S_EDGE:  head_raddr = t_idx;
			default: head_raddr = src_idx;
		endcase
		head_rd  = head_q[head_raddr];
		mem_we   = accept && (req.cmd == CMD_ADD) && add_ok;
		mem_re   = (state_q == S_TOP) && (sp_q != '0) && (top_c != NIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vcount_q     <= VCOUNT_RST;
			edges_used_q <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				head_q[i] <= NIL;
			end
			visited_q    <= '0;
			sp_q         <= '0;
			root_q       <= '0;
			fc_q         <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_ADD) begin
							res_valid_q <= 1'b1;
							if (add_ok) begin
								head_q[src_idx] <= edges_used_q;
								edges_used_q    <= edges_used_q + LW'(1);
							end
						end else begin
							visited_q <= '0;
							root_q    <= '0;
							fc_q      <= '0;
							sp_q      <= '0;
							state_q   <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (!root_in) begin
						state_q <= (fc_q == '0) ? S_IDLE : S_TOPO;
					end else if (visited_q[root_idx]) begin
						root_q <= root_q + NW'(1);
					end else begin
						visited_q[root_idx] <= 1'b1;
						res_valid_q         <= 1'b1;
						sp_q                <= NW'(1);
						state_q             <= S_TOP;
					end
				end
				S_TOP: begin
					if (sp_q == '0) begin
						root_q  <= root_q + NW'(1);
						state_q <= S_ROOT;
					end else if (top_c == NIL) begin
						sp_q <= sp_m1;
						fc_q <= fc_q + NW'(1);
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (t_ok) begin
						visited_q[t_idx] <= 1'b1;
						res_valid_q      <= 1'b1;
						sp_q             <= sp_q + NW'(1);
					end
					state_q <= S_TOP;
				end
				S_TOPO: begin
					res_valid_q <= 1'b1;
					fc_q        <= fc_m1;
					if (fc_q == NW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				result_q.kind         <= KIND_ACK;
				result_q.vertex       <= '0;
				result_q.edge_dropped <= !add_ok;
				result_q.last         <= 1'b1;
			end
			S_ROOT: begin
				stk_v_q[0]            <= root_idx;
				stk_c_q[0]            <= head_rd;
				result_q.kind         <= KIND_DISC;
				result_q.vertex       <= 4'(root_idx);
				result_q.edge_dropped <= 1'b0;
				result_q.last         <= 1'b0;
			end
			S_TOP: begin
				if ((sp_q != '0) && (top_c == NIL)) begin
					fin_q[fc_idx] <= top_v;
				end
			end
			S_EDGE: begin
				stk_c_q[top_idx] <= rd_next_q;
				if (t_ok) begin
					stk_v_q[sp_idx] <= t_idx;
					stk_c_q[sp_idx] <= head_rd;
				end
				result_q.kind         <= KIND_DISC;
				result_q.vertex       <= 4'(t_idx);
				result_q.edge_dropped <= 1'b0;
				result_q.last         <= 1'b0;
			end
			S_TOPO: begin
				result_q.kind         <= KIND_TOPO;
				result_q.vertex       <= 4'(fin_q[fc_m1[VW-1:0]]);
				result_q.edge_dropped <= 1'b0;
				result_q.last         <= (fc_q == NW'(1));
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	// edge memory: target and next link, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			edge_mem[edges_used_q[EW-1:0]] <= {req.edge_target, head_rd};
		end
		if (mem_re) begin
			{rd_tgt_q, rd_next_q} <= edge_mem[top_c[EW-1:0]];
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = result_q;

	`DFS_ASSERT(a_sp_range, 32'(sp_q) <= MAX_VERTICES, "stack pointer past depth")
	`DFS_ASSERT(a_fc_range, 32'(fc_q) <= MAX_VERTICES, "finish count past depth")
	`DFS_ASSERT_NEXT(a_add_ack, start && !busy && (req.cmd == CMD_ADD),
		result_valid && (result.kind == KIND_ACK) && result.last, "missing edge acknowledge")
	`DFS_ASSERT_IMP(a_last_kind, result_valid && result.last,
		(result.kind == KIND_ACK) || (result.kind == KIND_TOPO), "last on discovery result")
	`DFS_ASSERT_IMP(a_edge_after_top, state_q == S_EDGE, $past(mem_re),
		"edge step without memory read")

endmodule
`default_nettype wire

### verif/dfs_order_checker.sv
module dfs_order_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire dfs_pkg::dfs_req_t         req,
	input  wire logic                      cfg_we,
	input  wire logic [dfs_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      result_valid,
	input  wire dfs_pkg::dfs_result_t      result,
	output int                             pending,
	output int                             errors
);
	import dfs_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;
	localparam int NE = DEF_MAX_EDGES;
	localparam logic [6:0] NIL = 7'(NE);

	typedef enum logic [1:0] {VC_WHITE, VC_GRAY, VC_BLACK} vcolor_t;

	logic [CFG_W-1:0] vcount;
	logic [6:0]       adj_head [NV];
	logic [3:0]       edge_dst [NE];
	logic [6:0]       edge_link [NE];
	int unsigned      edge_cnt;
	dfs_result_t      expected_results [$];
	dfs_result_t      want;

	function automatic logic [6:0] live_link(logic [6:0] p);
		return (32'(p) < edge_cnt) ? p : NIL;
	endfunction

	function automatic dfs_result_t make_result(logic [1:0] k, logic [3:0] v, logic d);
		dfs_result_t r;
		r.kind = k;
		r.vertex = v;
		r.edge_dropped = d;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_request(dfs_req_t r);
		int n;
		int sp;
		int fc;
		int top;
		logic dropped;
		logic [3:0] v;
		logic [3:0] t;
		logic [6:0] cur;
		vcolor_t color [NV];
		logic [3:0] stk_v [NV];
		logic [6:0] stk_c [NV];
		logic [3:0] fin [NV];
		dfs_result_t out_q [$];
		n = (vcount > NV) ? NV : int'(vcount);
		if (r.cmd == CMD_ADD) begin
			dropped = 1'b1;
			if (edge_cnt < NE && r.edge_source < n && r.edge_target < n) begin
				edge_dst[edge_cnt] = r.edge_target;
				edge_link[edge_cnt] = adj_head[r.edge_source];
				adj_head[r.edge_source] = 7'(edge_cnt);
				edge_cnt++;
				dropped = 1'b0;
			end
			out_q.push_back(make_result(KIND_ACK, 4'd0, dropped));
		end else begin
			foreach (color[i]) color[i] = VC_WHITE;
			fc = 0;
			for (int root = 0; root < n; root++) begin
				if (color[root] != VC_WHITE) continue;
				color[root] = VC_GRAY;
				out_q.push_back(make_result(KIND_DISC, 4'(root), 1'b0));
				stk_v[0] = 4'(root);
				stk_c[0] = live_link(adj_head[root]);
				sp = 1;
				while (sp > 0) begin
					top = sp - 1;
					v = stk_v[top];
					cur = stk_c[top];
					if (cur == NIL) begin
						sp--;
						color[v] = VC_BLACK;
						if (fc < NV) begin
							fin[fc] = v;
							fc++;
						end
					end else begin
						t = edge_dst[cur];
						stk_c[top] = live_link(edge_link[cur]);
						if (t < n && color[t] == VC_WHITE && sp < NV) begin
							color[t] = VC_GRAY;
							out_q.push_back(make_result(KIND_DISC, t, 1'b0));
							stk_v[sp] = t;
							stk_c[sp] = live_link(adj_head[t]);
							sp++;
						end
					end
				end
			end
			for (int i = fc; i > 0; i--)
				out_q.push_back(make_result(KIND_TOPO, fin[i-1], 1'b0));
		end
		if (out_q.size() > 0) out_q[out_q.size()-1].last = 1'b1;
		foreach (out_q[i]) expected_results.push_back(out_q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount = VCOUNT_RST;
			edge_cnt = 0;
			foreach (adj_head[i]) adj_head[i] = NIL;
			expected_results.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (start && !busy) predict_request(req);
			if (cfg_we) vcount = cfg_wdata;
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual k%0d v%0d d%0d l%0d",
						$time, result.kind, result.vertex, result.edge_dropped, result.last);
				end else begin
					want = expected_results.pop_front();
					if (want.kind !== result.kind || want.vertex !== result.vertex ||
							want.edge_dropped !== result.edge_dropped || want.last !== result.last) begin
						errors++;
						$display("%0t: mismatch: expected k%0d v%0d d%0d l%0d, actual k%0d v%0d d%0d l%0d",
							$time, want.kind, want.vertex, want.edge_dropped, want.last,
							result.kind, result.vertex, result.edge_dropped, result.last);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

### verif/tb_dfs_topological_order_top.sv
module tb_dfs_topological_order_top;
	import dfs_pkg::*;

	localparam int LIMIT = 400000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	dfs_req_t         req;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             result_valid;
	dfs_result_t      result;
	int               pending;
	int               errors;
	int               cycles;
	int               items;
	int               vc_eff;
	bit               calm;

	dfs_topological_order_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	dfs_order_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result),
		.pending      (pending),
		.errors       (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_request(logic cmd, logic [3:0] src, logic [3:0] dst);
		int gap;
		dfs_req_t r;
		r.cmd = cmd;
		r.edge_source = src;
		r.edge_target = dst;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		items++;
	endtask

	// quiet: nothing expected, not busy, no result, counted over consecutive cycles
	task automatic settle();
		int quiet;
		quiet = 0;
		start <= 1'b0;
		while (quiet < 8) begin
			@(posedge clk);
			if (pending == 0 && !busy && !result_valid) quiet++;
			else quiet = 0;
		end
	endtask

	task automatic write_vcount(logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		vc_eff = (v > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(v);
	endtask

	task automatic random_item(int in_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < in_pct && vc_eff > 0)
			send_request(CMD_ADD, 4'($urandom_range(0, vc_eff - 1)),
				4'($urandom_range(0, vc_eff - 1)));
		else if (r < in_pct + 12)
			send_request(CMD_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		else
			send_request(CMD_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		int pick;
		int len;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		items = 0;
		calm = 1'b0;
		vc_eff = int'(VCOUNT_RST);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph at reset vertex count
		send_request(CMD_RUN, 4'hf, 4'hf);
		settle();
		write_vcount(5'd4);
		send_request(CMD_ADD, 4'd0, 4'd1);
		send_request(CMD_ADD, 4'd0, 4'd2);
		send_request(CMD_ADD, 4'd1, 4'd3);
		send_request(CMD_ADD, 4'd2, 4'd3);
		send_request(CMD_ADD, 4'd3, 4'd3);
		send_request(CMD_ADD, 4'd4, 4'd0);
		send_request(CMD_ADD, 4'd0, 4'd15);
		send_request(CMD_RUN, 4'd0, 4'd0);
		settle();
		write_vcount(5'd31);
		send_request(CMD_ADD, 4'd15, 4'd0);
		send_request(CMD_ADD, 4'd0, 4'd15);
		send_request(CMD_RUN, 4'd0, 4'd0);
		settle();
		// stale edges above the count
		write_vcount(5'd2);
		send_request(CMD_RUN, 4'd0, 4'd0);
		send_request(CMD_ADD, 4'd1, 4'd0);
		send_request(CMD_ADD, 4'd2, 4'd1);
		send_request(CMD_RUN, 4'd0, 4'd0);
		settle();
		write_vcount(5'd0);
		send_request(CMD_ADD, 4'd0, 4'd0);
		send_request(CMD_RUN, 4'd0, 4'd0);
		settle();
		write_vcount(5'd1);
		send_request(CMD_RUN, 4'd0, 4'd0);
		send_request(CMD_ADD, 4'd0, 4'd0);
		send_request(CMD_RUN, 4'd0, 4'd0);

		while (items < 160) begin
			settle();
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_vcount(5'd0);
				1: write_vcount(5'd1);
				2: write_vcount(5'd16);
				3: write_vcount(5'd31);
				4: write_vcount(5'd17);
				default: write_vcount(5'($urandom_range(2, 16)));
			endcase
			len = $urandom_range(4, 14);
			repeat (len) random_item(70);
			send_request(CMD_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		end

		// fill the edge memory past capacity, no idling
		settle();
		calm = 1'b1;
		write_vcount(5'd16);
		repeat (70) random_item(80);
		send_request(CMD_RUN, 4'd0, 4'd0);
		settle();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
